>>> rtl/jsu_pkg.sv
// Shared types and constants of the JSON string unescape unit.
package jsu_pkg;

  localparam int MaxRes = 4;
  localparam int CntW   = $clog2(MaxRes + 1);
  localparam int IdxW   = $clog2(MaxRes);

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } jsu_kind_e;

  typedef enum logic [2:0] {
    ERR_NO_QUOTE   = 3'd0,
    ERR_CTRL       = 3'd1,
    ERR_BAD_ESC    = 3'd2,
    ERR_BAD_HEX    = 3'd3,
    ERR_UNPAIR_HI  = 3'd4,
    ERR_BAD_LOW    = 3'd5,
    ERR_UNPAIR_LO  = 3'd6,
    ERR_BAD_UTF8   = 3'd7
  } jsu_err_e;

  typedef struct packed {
    jsu_kind_e   kind;
    logic [7:0]  data;
    logic [2:0]  code;
  } jsu_res_t;

  typedef struct packed {
    jsu_res_t [MaxRes-1:0] res;
    logic [CntW-1:0]       cnt;
  } jsu_grp_t;

endpackage

>>> rtl/jsu_in_if.sv
// Input byte channel of the JSON string unescape unit.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> rtl/jsu_out_if.sv
// Result word channel of the JSON string unescape unit.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink (input valid, input kind, input out_byte, input error_code,
                input last, output ready);
endinterface

>>> rtl/jsu_decode.sv
// Parser state and one-pass decode of an input byte into a group of result words.
module jsu_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  output jsu_pkg::jsu_grp_t grp_o
);
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_STR     = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX     = 4'd3,
    PH_LOW_BS  = 4'd4,
    PH_LOW_U   = 4'd5,
    PH_LOW_HEX = 4'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [11:0] hex_acc_q, hex_acc_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [9:0]  hi_bits_q, hi_bits_d;
  logic [1:0]  u8_pend_q, u8_pend_d;
  logic [1:0]  u8_len_q, u8_len_d;
  logic [4:0]  u8_lead_q, u8_lead_d;

  logic        fail;
  jsu_err_e    fail_code;
  logic [4:0]  hex_d;
  logic [15:0] hex_full;
  logic [10:0] cp2;
  logic        u8_bad;
  logic [20:0] cp_pair;
  logic [7:0]  b;

  function automatic jsu_res_t data_res(input logic [7:0] d);
    jsu_res_t r;
    r.kind = KIND_DATA;
    r.data = d;
    r.code = '0;
    return r;
  endfunction

  function automatic jsu_grp_t push(input jsu_grp_t g, input logic [7:0] d);
    jsu_grp_t r;
    r = g;
    r.res[g.cnt[IdxW-1:0]] = data_res(d);
    r.cnt = g.cnt + CntW'(1);
    return r;
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  function automatic jsu_grp_t enc_utf8(input logic [20:0] cp);
    jsu_grp_t g;
    g = '0;
    if (cp <= 21'h7F) begin
      g = push(g, cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      g = push(g, {3'b110, cp[10:6]});
      g = push(g, {2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      g = push(g, {4'b1110, cp[15:12]});
      g = push(g, {2'b10, cp[11:6]});
      g = push(g, {2'b10, cp[5:0]});
    end else begin
      g = push(g, {5'b11110, cp[20:18]});
      g = push(g, {2'b10, cp[17:12]});
      g = push(g, {2'b10, cp[11:6]});
      g = push(g, {2'b10, cp[5:0]});
    end
    return g;
  endfunction

  assign b        = in_byte_i;
  assign hex_d    = hex_value(b);
  assign hex_full = {hex_acc_q, hex_d[3:0]};
  assign cp2      = {u8_lead_q, b[5:0]};
  assign cp_pair  = 21'h10000 + {1'b0, hi_bits_q, hex_full[9:0]};
  assign u8_bad   = (u8_pend_q == u8_len_q) &&
                    ((u8_len_q == 2'd2 && (cp2 < 11'h20 ||
                                           (cp2 >= 11'h360 && cp2 <= 11'h37F))) ||
                     (u8_len_q == 2'd3 && (cp2 < 11'h10 || cp2 > 11'h10F)));

  always_comb begin
    phase_d   = phase_q;
    hex_acc_d = hex_acc_q;
    hex_cnt_d = hex_cnt_q;
    hi_bits_d = hi_bits_q;
    u8_pend_d = u8_pend_q;
    u8_len_d  = u8_len_q;
    u8_lead_d = u8_lead_q;
    fail      = 1'b0;
    fail_code = ERR_NO_QUOTE;
    grp_o     = '0;

    case (phase_q)
      PH_STR: begin
        if (b == "\"") begin
          if (u8_pend_q != 2'd0) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_UTF8;
          end else begin
            grp_o.res[0].kind = KIND_DONE;
            grp_o.cnt         = CntW'(1);
            phase_d           = PH_IDLE;
            hex_acc_d         = '0;
            hex_cnt_d         = '0;
            hi_bits_d         = '0;
          end
        end else if (b < 8'h20) begin
          fail      = 1'b1;
          fail_code = ERR_CTRL;
        end else if (b == "\\") begin
          if (u8_pend_q != 2'd0) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_UTF8;
          end else begin
            phase_d = PH_ESC;
          end
        end else if (u8_pend_q == 2'd0) begin
          if (!b[7]) begin
            grp_o = push(grp_o, b);
          end else if (b >= 8'hC2 && b <= 8'hDF) begin
            u8_len_d  = 2'd1;
            u8_pend_d = 2'd1;
            u8_lead_d = b[4:0];
            grp_o     = push(grp_o, b);
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            u8_len_d  = 2'd2;
            u8_pend_d = 2'd2;
            u8_lead_d = {1'b0, b[3:0]};
            grp_o     = push(grp_o, b);
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            u8_len_d  = 2'd3;
            u8_pend_d = 2'd3;
            u8_lead_d = {2'b00, b[2:0]};
            grp_o     = push(grp_o, b);
          end else begin
            fail      = 1'b1;
            fail_code = ERR_BAD_UTF8;
          end
        end else if (b[7:6] != 2'b10 || u8_bad) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_UTF8;
        end else begin
          u8_pend_d = u8_pend_q - 2'd1;
          if (u8_pend_q == 2'd1) begin
            u8_len_d  = '0;
            u8_lead_d = '0;
          end
          grp_o = push(grp_o, b);
        end
      end
      PH_ESC: begin
        phase_d = PH_STR;
        case (b)
          "\"":    grp_o = push(grp_o, b);
          "\\":    grp_o = push(grp_o, b);
          "/":     grp_o = push(grp_o, b);
          "b":     grp_o = push(grp_o, 8'h08);
          "f":     grp_o = push(grp_o, 8'h0C);
          "n":     grp_o = push(grp_o, 8'h0A);
          "r":     grp_o = push(grp_o, 8'h0D);
          "t":     grp_o = push(grp_o, 8'h09);
          "u": begin
            phase_d   = PH_HEX;
            hex_acc_d = '0;
            hex_cnt_d = '0;
          end
          default: begin
            fail      = 1'b1;
            fail_code = ERR_BAD_ESC;
          end
        endcase
      end
      PH_HEX, PH_LOW_HEX: begin
        if (!hex_d[4]) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_HEX;
        end else if (hex_cnt_q != 2'd3) begin
          hex_acc_d = hex_full[11:0];
          hex_cnt_d = hex_cnt_q + 2'd1;
        end else begin
          hex_acc_d = '0;
          hex_cnt_d = '0;
          if (phase_q == PH_HEX) begin
            if (hex_full >= 16'hD800 && hex_full <= 16'hDBFF) begin
              hi_bits_d = hex_full[9:0];
              phase_d   = PH_LOW_BS;
            end else if (hex_full >= 16'hDC00 && hex_full <= 16'hDFFF) begin
              fail      = 1'b1;
              fail_code = ERR_UNPAIR_LO;
            end else begin
              grp_o   = enc_utf8({5'd0, hex_full});
              phase_d = PH_STR;
            end
          end else if (hex_full < 16'hDC00 || hex_full > 16'hDFFF) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_LOW;
          end else begin
            grp_o     = enc_utf8(cp_pair);
            hi_bits_d = '0;
            phase_d   = PH_STR;
          end
        end
      end
      PH_LOW_BS: begin
        if (b == "\\") begin
          phase_d = PH_LOW_U;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_UNPAIR_HI;
        end
      end
      PH_LOW_U: begin
        if (b == "u") begin
          phase_d   = PH_LOW_HEX;
          hex_acc_d = '0;
          hex_cnt_d = '0;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_UNPAIR_HI;
        end
      end
      default: begin
        if (b == "\"") begin
          phase_d   = PH_STR;
          hex_acc_d = '0;
          hex_cnt_d = '0;
          hi_bits_d = '0;
          u8_pend_d = '0;
          u8_len_d  = '0;
          u8_lead_d = '0;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_NO_QUOTE;
        end
      end
    endcase

    if (fail) begin
      grp_o             = '0;
      grp_o.res[0].kind = KIND_ERR;
      grp_o.res[0].code = fail_code;
      grp_o.cnt         = CntW'(1);
      phase_d           = PH_IDLE;
      hex_acc_d         = '0;
      hex_cnt_d         = '0;
      hi_bits_d         = '0;
      u8_pend_d         = '0;
      u8_len_d          = '0;
      u8_lead_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hex_acc_q <= '0;
      hex_cnt_q <= '0;
      hi_bits_q <= '0;
      u8_pend_q <= '0;
      u8_len_q  <= '0;
      u8_lead_q <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      hex_acc_q <= hex_acc_d;
      hex_cnt_q <= hex_cnt_d;
      hi_bits_q <= hi_bits_d;
      u8_pend_q <= u8_pend_d;
      u8_len_q  <= u8_len_d;
      u8_lead_q <= u8_lead_d;
    end
  end

  a_err_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && grp_o.cnt != '0 && grp_o.res[0].kind == KIND_ERR) |=> phase_q == PH_IDLE)
    else $error("error word did not return parser to idle");

  a_multi_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_o.cnt > CntW'(1) |-> (grp_o.res[0].kind == KIND_DATA &&
                              grp_o.res[1].kind == KIND_DATA))
    else $error("multi-word group holds a non-data word");

  a_pend_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u8_pend_q <= u8_len_q)
    else $error("pending continuation count exceeds sequence length");

endmodule

>>> rtl/jsu_emit.sv
// Result group register that hands out its words one per handshake.
module jsu_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  jsu_pkg::jsu_grp_t grp_i,
  output logic              ready_o,
  jsu_out_if.source         out_o
);
  import jsu_pkg::*;

  jsu_grp_t        grp_q;
  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  jsu_res_t        cur;
  logic            last_w;
  logic            take;

  assign cur    = grp_q.res[idx_q];
  assign last_w = ({1'b0, idx_q} == grp_q.cnt - CntW'(1));
  assign take   = busy_q && out_o.ready;
  assign ready_o = !busy_q || (out_o.ready && last_w);

  assign out_o.valid      = busy_q;
  assign out_o.kind       = cur.kind;
  assign out_o.out_byte   = cur.data;
  assign out_o.error_code = cur.code;
  assign out_o.last       = last_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i && grp_i.cnt != '0) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      if (last_w) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && grp_i.cnt != '0) begin
      grp_q <= grp_i;
    end
  end

  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (grp_q.cnt != '0 && {1'b0, idx_q} < grp_q.cnt))
    else $error("word index outside loaded group");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_w && !load_i) |=> !busy_q)
    else $error("group not released after last word");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && busy_q) |-> (take && last_w))
    else $error("group loaded over undelivered words");

endmodule

>>> rtl/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescape and UTF-8 validation unit.
// The first result word of a byte is registered and valid in the cycle after the byte is taken.
// Throughput: one byte per cycle while the output is ready and each byte gives at most
// one word; a byte that gives more words (a \u escape encodes to up to four) holds the
// input until the single result group register has drained, one word per ready cycle.
// Reset: parser returns to idle awaiting an opening quote, result register empties.
module json_string_unescape_utf8_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  jsu_grp_t grp;
  logic     accept;
  logic     ready;

  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .grp_o     (grp)
  );

  jsu_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .grp_i   (grp),
    .ready_o (ready),
    .out_o   (out_o)
  );

endmodule
